// File: sv/pn3d_pkg.sv
// pn3d_pkg: permutation table, register indexes and scale limits for the 3D noise pipeline.
// No dependencies.
package pn3d_pkg;

  localparam int unsigned REG_INV_SCALE = 0;
  localparam int unsigned REG_OFFSET_X  = 1;
  localparam int unsigned REG_OFFSET_Y  = 2;
  localparam int unsigned REG_OFFSET_Z  = 3;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned INV_W         = 17;
  localparam logic [INV_W-1:0] INV_MAX  = 17'd65536;
  localparam logic [INV_W-1:0] INV_MIN  = 17'd1;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,
    8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,
    8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,
    8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,
    8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,
    8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,
    8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
    8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
    8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,
    8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] perm(input logic [7:0] i);
    perm = PERM[i];
  endfunction

endpackage

// File: sv/perlin_noise_3d.sv
// perlin_noise_3d: pipelined improved Perlin noise, 3D, fixed point.
// Depends on pn3d_pkg (permutation table, register indexes).
//
// channel  dir  fields (low bit up)                       transfer when
// s_axis   in   tdata: coord_x[31:0] coord_y coord_z      s_axis_tvalid & s_axis_tready
// m_axis   out  tdata: noise_value[15:0]                  m_axis_tvalid & m_axis_tready
// cfg      in   cfg_index 0..3, cfg_data                  cfg_we
//
// One point per cycle while the output is not stalled.
// The depth is set by the serial fade chain (t^2..t^5, one multiply per stage)
// and the three lerp levels, each a multiply and an add on its own stages.
// All stages advance together on a global enable; a stalled output freezes the
// whole pipe, so nothing is lost or repeated. s_axis_tready is low only while the
// final stage holds a result that is not taken in that cycle.
// Reset (rst, synchronous) clears valid bits and the offset registers and sets inv_scale to INV_MAX.
module perlin_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // coord_x[31:0], coord_y[63:32], coord_z[95:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // noise_value[15:0]
  input  logic        cfg_we,
  input  logic [pn3d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pn3d_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pn3d_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int NST  = 14;
  localparam int FW   = F + 1;          // fraction-ish value 0..1 inclusive
  localparam int GW   = F + 4;          // gradient and lerp values, signed
  localparam int CW   = 8;

  // ---------------- configuration
  logic [INV_W-1:0]  inv_scale;
  logic signed [31:0] off_x, off_y, off_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale <= INV_MAX;
      off_x <= '0;
      off_y <= '0;
      off_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_W'(REG_INV_SCALE): inv_scale <= cfg_data[INV_W-1:0];
        CFG_IDX_W'(REG_OFFSET_X):  off_x <= cfg_data;
        CFG_IDX_W'(REG_OFFSET_Y):  off_y <= cfg_data;
        CFG_IDX_W'(REG_OFFSET_Z):  off_z <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [INV_W-1:0] scl;
  always_comb begin
    scl = inv_scale;
    if (inv_scale == '0) scl = INV_MIN;
    if (inv_scale > INV_MAX) scl = INV_MAX;
  end

  // ---------------- pipeline control
  logic [NST-1:0] vld;
  logic           en;
  assign en = !vld[NST-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NST-2:0], s_axis_tvalid};
  end

  // ---------------- stage 1: add offsets
  logic signed [32:0] s1_sum [3];
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum[0] <= 33'(signed'(s_axis_tdata[31:0]))  + 33'(off_x);
      s1_sum[1] <= 33'(signed'(s_axis_tdata[63:32])) + 33'(off_y);
      s1_sum[2] <= 33'(signed'(s_axis_tdata[95:64])) + 33'(off_z);
    end
  end

  // ---------------- stage 2: scale (33 x 17 signed product)
  logic signed [50:0] s2_prod [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        s2_prod[i] <= 51'(s1_sum[i]) * signed'(51'(scl));
    end
  end

  // ---------------- stage 3: split into cell and fraction, first perm lookup
  logic [CW-1:0] s3_cy, s3_cz, s3_pa, s3_pb;
  logic [F-1:0]  s3_fr [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) s3_fr[i] <= s2_prod[i][32-F +: F];
      s3_pa <= perm(s2_prod[0][32 +: CW]);
      s3_pb <= perm(s2_prod[0][32 +: CW] + 8'd1);
      s3_cy <= s2_prod[1][32 +: CW];
      s3_cz <= s2_prod[2][32 +: CW];
    end
  end

  // ---------------- stage 4: a, b rows; t^2
  logic [CW-1:0] s4_aa, s4_ab, s4_ba, s4_bb;
  logic [F-1:0]  s4_fr [3];
  logic [F-1:0]  s4_t2 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      s4_aa <= perm(s3_pa + s3_cy) + s3_cz;
      s4_ab <= perm(s3_pa + s3_cy + 8'd1) + s3_cz;
      s4_ba <= perm(s3_pb + s3_cy) + s3_cz;
      s4_bb <= perm(s3_pb + s3_cy + 8'd1) + s3_cz;
      for (int i = 0; i < 3; i++) begin
        s4_fr[i] <= s3_fr[i];
        s4_t2[i] <= F'((2*F)'(s3_fr[i]) * (2*F)'(s3_fr[i]) >> F);
      end
    end
  end

  // ---------------- stage 5: corner hashes; t^3
  logic [3:0]   s5_h [8];
  logic [F-1:0] s5_fr [3];
  logic [F-1:0] s5_t3 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      // corner index = {dz, dy, dx}
      s5_h[0] <= 4'(perm(s4_aa));
      s5_h[1] <= 4'(perm(s4_ba));
      s5_h[2] <= 4'(perm(s4_ab));
      s5_h[3] <= 4'(perm(s4_bb));
      s5_h[4] <= 4'(perm(s4_aa + 8'd1));
      s5_h[5] <= 4'(perm(s4_ba + 8'd1));
      s5_h[6] <= 4'(perm(s4_ab + 8'd1));
      s5_h[7] <= 4'(perm(s4_bb + 8'd1));
      for (int i = 0; i < 3; i++) begin
        s5_fr[i] <= s4_fr[i];
        s5_t3[i] <= F'((2*F)'(s4_t2[i]) * (2*F)'(s4_fr[i]) >> F);
      end
    end
  end

  // gradient: sums of +-frac and +-(frac-1)
  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
      input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
      input logic signed [GW-1:0] z);
    logic signed [GW-1:0] u, v;
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    grad = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // ---------------- stage 6: gradients; t^4
  logic signed [GW-1:0] s6_g [8];
  logic [F-1:0] s6_fr [3];
  logic [F-1:0] s6_t3 [3];
  logic [F-1:0] s6_t4 [3];
  logic signed [GW-1:0] c0 [3], c1 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c0[i] = GW'(s5_fr[i]);
      c1[i] = GW'(s5_fr[i]) - (GW'(1) <<< F);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++)
        s6_g[k] <= grad(s5_h[k], k[0] ? c1[0] : c0[0], k[1] ? c1[1] : c0[1],
                        k[2] ? c1[2] : c0[2]);
      for (int i = 0; i < 3; i++) begin
        s6_fr[i] <= s5_fr[i];
        s6_t3[i] <= s5_t3[i];
        s6_t4[i] <= F'((2*F)'(s5_t3[i]) * (2*F)'(s5_fr[i]) >> F);
      end
    end
  end

  // ---------------- stage 7: t^5; x-differences
  logic signed [GW-1:0] s7_g [8];
  logic signed [GW:0]   s7_d [4];
  logic [F-1:0] s7_t3 [3], s7_t4 [3], s7_t5 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) s7_g[k] <= s6_g[k];
      for (int j = 0; j < 4; j++)
        s7_d[j] <= (GW+1)'(s6_g[2*j+1]) - (GW+1)'(s6_g[2*j]);
      for (int i = 0; i < 3; i++) begin
        s7_t3[i] <= s6_t3[i];
        s7_t4[i] <= s6_t4[i];
        s7_t5[i] <= F'((2*F)'(s6_t4[i]) * (2*F)'(s6_fr[i]) >> F);
      end
    end
  end

  // ---------------- stage 8: fade sum, clamped to 0..1
  localparam int SW = F + 6;
  logic signed [SW-1:0] fsum [3];
  logic [FW-1:0] s8_f [3];
  logic signed [GW-1:0] s8_g [4];
  logic signed [GW:0]   s8_d [4];
  always_comb begin
    for (int i = 0; i < 3; i++)
      fsum[i] = SW'(6) * SW'(s7_t5[i]) - SW'(15) * SW'(s7_t4[i])
              + SW'(10) * SW'(s7_t3[i]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (fsum[i] < 0) s8_f[i] <= '0;
        else if (fsum[i] > (SW'(1) <<< F)) s8_f[i] <= FW'(1) << F;
        else s8_f[i] <= FW'(fsum[i]);
      end
      for (int j = 0; j < 4; j++) begin
        s8_g[j] <= s7_g[2*j];
        s8_d[j] <= s7_d[j];
      end
    end
  end

  // lerp product: floor(t * d / 2^F)
  localparam int PW = GW + FW + 2;
  function automatic logic signed [GW:0] mulq(input logic [FW-1:0] t,
      input logic signed [GW:0] d);
    logic signed [PW-1:0] p;
    p = PW'(d) * signed'(PW'(t));
    mulq = (GW+1)'(p >>> F);
  endfunction

  // ---------------- stage 9: x products
  logic signed [GW:0] s9_p [4];
  logic signed [GW-1:0] s9_g [4];
  logic [FW-1:0] s9_f [2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s9_p[j] <= mulq(s8_f[0], s8_d[j]);
        s9_g[j] <= s8_g[j];
      end
      s9_f[0] <= s8_f[1];
      s9_f[1] <= s8_f[2];
    end
  end

  // ---------------- stage 10: x lerp results and y differences
  logic signed [GW-1:0] s10_a [2];
  logic signed [GW:0]   s10_d [2];
  logic [FW-1:0] s10_f [2];
  logic signed [GW-1:0] lx [4];
  always_comb begin
    for (int j = 0; j < 4; j++) lx[j] = s9_g[j] + GW'(s9_p[j]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        s10_a[j] <= lx[2*j];
        s10_d[j] <= (GW+1)'(lx[2*j+1]) - (GW+1)'(lx[2*j]);
      end
      s10_f <= s9_f;
    end
  end

  // ---------------- stage 11: y products
  logic signed [GW:0]   s11_p [2];
  logic signed [GW-1:0] s11_a [2];
  logic [FW-1:0] s11_w;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 2; j++) begin
        s11_p[j] <= mulq(s10_f[0], s10_d[j]);
        s11_a[j] <= s10_a[j];
      end
      s11_w <= s10_f[1];
    end
  end

  // ---------------- stage 12: y lerp results, z difference
  logic signed [GW-1:0] r0, r1;
  logic signed [GW-1:0] s12_a;
  logic signed [GW:0]   s12_d;
  logic [FW-1:0] s12_w;
  assign r0 = s11_a[0] + GW'(s11_p[0]);
  assign r1 = s11_a[1] + GW'(s11_p[1]);
  always_ff @(posedge clk) begin
    if (en) begin
      s12_a <= r0;
      s12_d <= (GW+1)'(r1) - (GW+1)'(r0);
      s12_w <= s11_w;
    end
  end

  // ---------------- stage 13: z product
  logic signed [GW:0]   s13_p;
  logic signed [GW-1:0] s13_a;
  always_ff @(posedge clk) begin
    if (en) begin
      s13_p <= mulq(s12_w, s12_d);
      s13_a <= s12_a;
    end
  end

  // ---------------- stage 14: map to 0..1, saturate, output register
  localparam int VW = GW + 2;
  logic signed [VW-1:0] val;
  logic [VW-1:0] vcl;
  logic [VW+16-1:0] qv;
  logic [15:0] q;
  always_comb begin
    val = VW'(s13_a) + VW'(s13_p) + (VW'(1) <<< F);
    if (val < 0) vcl = '0;
    else if (val > (VW'(2) <<< F)) vcl = VW'(2) << F;
    else vcl = VW'(val);
    qv = ((VW+16)'(vcl) << 16) >> (F + 1);
    q = (qv > (VW+16)'(65535)) ? 16'hFFFF : qv[15:0];
  end
  always_ff @(posedge clk) begin
    if (en) m_axis_tdata <= q;
  end
  assign m_axis_tvalid = vld[NST-1];

`ifndef NO_ASSERTIONS
  // a held result keeps its value until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // a stall freezes every stage's valid bit
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved during stall");
  // an accepted point occupies the first stage on the next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted point missing from first stage");
`endif
endmodule
